// ----- design/cksb_pkg.sv -----
// Shared types and constants for the color-key sprite blitter.
// Used by cksb_csr, cksb_scan, cksb_pixel and the top level; no dependencies.
`default_nettype none

package cksb_pkg;

   // Screen size limit applied to clipping and row stride
   localparam int unsigned MAX_RESOLUTION = 2047;
   localparam logic [11:0] MAX_RES        = 12'(MAX_RESOLUTION);

   localparam int unsigned ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_PIXEL_BYTES   = 3'd2,
      REG_TRANSP_KEY    = 3'd3,
      REG_BUFFER_BASE   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [31:0]        pixel_color;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [10:0]        sprite_width;
      logic [10:0]        sprite_height;
      logic               first_pixel;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [24:0] pixel_address;
      logic [31:0] write_color;
      logic        sprite_done;
   } rsp_type;

   // Effective configuration, already clamped
   typedef struct packed {
      logic [10:0] screen_width;
      logic [10:0] screen_height;
      logic [2:0]  pixel_bytes;
      logic [31:0] transparency_key;
      logic [23:0] buffer_base;
      logic [12:0] row_stride;
   } cfg_type;

   // Word between scan stage and pixel stages
   typedef struct packed {
      logic [31:0] color;
      logic [15:0] x;
      logic [15:0] y;
      logic        done;
   } walk_type;

endpackage

`default_nettype wire

// ----- design/cksb_csr.sv -----
// Configuration registers with APB-style access and clamped effective values.
// Depends on cksb_pkg.
`default_nettype none

module cksb_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [cksb_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output cksb_pkg::cfg_type               cfg
);
   import cksb_pkg::*;

   logic [10:0]   screen_width_ff;
   logic [10:0]   screen_height_ff;
   logic [2:0]    pixel_bytes_ff;
   logic [31:0]   transparency_key_ff;
   logic [23:0]   buffer_base_ff;
   logic [12:0]   row_stride_ff;
   logic [12:0]   row_stride_in;
   logic [10:0]   sw_eff;
   logic [10:0]   sh_eff;
   logic [2:0]    bytes_eff;
   logic          wr_en;
   reg_index_type reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff     <= 11'd1024;
         screen_height_ff    <= 11'd768;
         pixel_bytes_ff      <= 3'd1;
         transparency_key_ff <= 32'd0;
         buffer_base_ff      <= 24'd0;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_SCREEN_WIDTH:  screen_width_ff     <= pwdata[10:0];
            REG_SCREEN_HEIGHT: screen_height_ff    <= pwdata[10:0];
            REG_PIXEL_BYTES:   pixel_bytes_ff      <= pwdata[2:0];
            REG_TRANSP_KEY:    transparency_key_ff <= pwdata;
            REG_BUFFER_BASE:   buffer_base_ff      <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SCREEN_WIDTH:  prdata = {21'd0, screen_width_ff};
         REG_SCREEN_HEIGHT: prdata = {21'd0, screen_height_ff};
         REG_PIXEL_BYTES:   prdata = {29'd0, pixel_bytes_ff};
         REG_TRANSP_KEY:    prdata = transparency_key_ff;
         REG_BUFFER_BASE:   prdata = {8'd0, buffer_base_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // clamp screen size, map pixel_bytes 0 -> 1 and 5..7 -> 4
   assign sw_eff = ({1'b0, screen_width_ff} > MAX_RES) ? MAX_RES[10:0] : screen_width_ff;
   assign sh_eff = ({1'b0, screen_height_ff} > MAX_RES) ? MAX_RES[10:0] : screen_height_ff;

   always_comb begin
      if (pixel_bytes_ff == 3'd0) begin
         bytes_eff = 3'd1;
      end else if (pixel_bytes_ff > 3'd4) begin
         bytes_eff = 3'd4;
      end else begin
         bytes_eff = pixel_bytes_ff;
      end
   end

   // row byte stride registered; user moves config only while idle, unchecked
   assign row_stride_in = {2'd0, sw_eff} * {10'd0, bytes_eff};

   always_ff @(posedge clock) begin
      row_stride_ff <= row_stride_in;
   end

   assign cfg.screen_width     = sw_eff;
   assign cfg.screen_height    = sh_eff;
   assign cfg.pixel_bytes      = bytes_eff;
   assign cfg.transparency_key = transparency_key_ff;
   assign cfg.buffer_base      = buffer_base_ff;
   assign cfg.row_stride       = row_stride_ff;

endmodule

`default_nettype wire

// ----- design/cksb_scan.sv -----
// Sprite raster walker: holds origin/size, runs row and column counters and
// registers the screen coordinate of each accepted pixel. Depends on cksb_pkg.
`default_nettype none

module cksb_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire cksb_pkg::req_type  req_data,
   output logic                    s1_valid,
   input  wire logic               s1_ready,
   output cksb_pkg::walk_type      s1_data
);
   import cksb_pkg::*;

   logic [15:0] held_origin_x_ff;
   logic [15:0] held_origin_y_ff;
   logic [10:0] held_width_ff;
   logic [10:0] held_height_ff;
   logic [10:0] column_count_ff;
   logic [10:0] row_count_ff;
   logic        s1_valid_ff;
   walk_type    s1_data_ff;

   logic [15:0] ox_cur;
   logic [15:0] oy_cur;
   logic [10:0] w_cur;
   logic [10:0] h_cur;
   logic [10:0] col_cur;
   logic [10:0] row_cur;
   logic [10:0] w_eff;
   logic [10:0] h_eff;
   logic [10:0] column_count_in;
   logic [10:0] row_count_in;
   logic        done;
   logic        accept;
   logic [10:0] held_w_eff;
   logic [10:0] held_h_eff;

   assign req_ready = !s1_valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;

   // first pixel takes the fresh origin/size and restarts the counters
   assign ox_cur  = req_data.first_pixel ? req_data.origin_x      : held_origin_x_ff;
   assign oy_cur  = req_data.first_pixel ? req_data.origin_y      : held_origin_y_ff;
   assign w_cur   = req_data.first_pixel ? req_data.sprite_width  : held_width_ff;
   assign h_cur   = req_data.first_pixel ? req_data.sprite_height : held_height_ff;
   assign col_cur = req_data.first_pixel ? 11'd0 : column_count_ff;
   assign row_cur = req_data.first_pixel ? 11'd0 : row_count_ff;

   assign w_eff = (w_cur == 11'd0) ? 11'd1 : w_cur;
   assign h_eff = (h_cur == 11'd0) ? 11'd1 : h_cur;

   always_comb begin
      done            = 1'b0;
      row_count_in    = row_cur;
      column_count_in = col_cur + 11'd1;
      if (({1'b0, col_cur} + 12'd1) >= {1'b0, w_eff}) begin
         column_count_in = 11'd0;
         if (({1'b0, row_cur} + 12'd1) >= {1'b0, h_eff}) begin
            row_count_in = 11'd0;
            done         = 1'b1;
         end else begin
            row_count_in = row_cur + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_origin_x_ff <= 16'd0;
         held_origin_y_ff <= 16'd0;
         held_width_ff    <= 11'd0;
         held_height_ff   <= 11'd0;
         column_count_ff  <= 11'd0;
         row_count_ff     <= 11'd0;
         s1_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            held_origin_x_ff <= ox_cur;
            held_origin_y_ff <= oy_cur;
            held_width_ff    <= w_cur;
            held_height_ff   <= h_cur;
            column_count_ff  <= column_count_in;
            row_count_ff     <= row_count_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   // coordinate wraps to 16 bits
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff.color <= req_data.pixel_color;
         s1_data_ff.x     <= ox_cur + {5'd0, col_cur};
         s1_data_ff.y     <= oy_cur + {5'd0, row_cur};
         s1_data_ff.done  <= done;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

   assign held_w_eff = (held_width_ff == 11'd0)  ? 11'd1 : held_width_ff;
   assign held_h_eff = (held_height_ff == 11'd0) ? 11'd1 : held_height_ff;

   a_col_in_sprite: assert property (@(posedge clock) disable iff (reset)
      column_count_ff < held_w_eff)
      else $error("column counter beyond sprite width");

   a_row_in_sprite: assert property (@(posedge clock) disable iff (reset)
      row_count_ff < held_h_eff)
      else $error("row counter beyond sprite height");

endmodule

`default_nettype wire

// ----- design/cksb_pixel.sv -----
// Clip, color key and address stages: stage 2 forms the row product,
// the output stage adds base and column offset. Depends on cksb_pkg.
`default_nettype none

module cksb_pixel (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cksb_pkg::cfg_type   cfg,
   input  wire logic                s1_valid,
   output logic                     s1_ready,
   input  wire cksb_pkg::walk_type  s1_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output cksb_pkg::rsp_type        rsp_data
);
   import cksb_pkg::*;

   logic        s2_valid_ff;
   logic        s2_we_ff;
   logic [31:0] s2_color_ff;
   logic [23:0] s2_prod_ff;
   logic [12:0] s2_xoff_ff;
   logic        s2_done_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic        s2_adv;
   logic        s3_adv;
   logic [31:0] color_mask;
   logic [31:0] color_m;
   logic        on_screen;
   logic        we;
   logic [23:0] prod;
   logic [12:0] xoff;
   logic [24:0] addr_sum;

   assign s3_adv   = !rsp_valid_ff || rsp_ready;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_ready = s2_adv;

   always_comb begin
      case (cfg.pixel_bytes)
         3'd1:    color_mask = 32'h0000_00FF;
         3'd2:    color_mask = 32'h0000_FFFF;
         3'd3:    color_mask = 32'h00FF_FFFF;
         default: color_mask = 32'hFFFF_FFFF;
      endcase
   end

   assign color_m   = s1_data.color & color_mask;
   assign on_screen = !s1_data.x[15] && !s1_data.y[15] &&
                      (s1_data.x[14:0] < {4'd0, cfg.screen_width}) &&
                      (s1_data.y[14:0] < {4'd0, cfg.screen_height});
   assign we        = on_screen && (color_m != cfg.transparency_key);

   // y fits 11 bits whenever the pixel is on screen
   assign prod = {13'd0, s1_data.y[10:0]} * {11'd0, cfg.row_stride};

   always_comb begin
      case (cfg.pixel_bytes)
         3'd1:    xoff = {2'd0, s1_data.x[10:0]};
         3'd2:    xoff = {1'b0, s1_data.x[10:0], 1'b0};
         3'd3:    xoff = {1'b0, s1_data.x[10:0], 1'b0} + {2'd0, s1_data.x[10:0]};
         default: xoff = {s1_data.x[10:0], 2'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s2_adv) begin
            s2_valid_ff <= s1_valid;
         end
         if (s3_adv) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_we_ff    <= we;
         s2_color_ff <= color_m;
         s2_prod_ff  <= prod;
         s2_xoff_ff  <= xoff;
         s2_done_ff  <= s1_data.done;
      end
   end

   // address modulo 2^25
   assign addr_sum = {1'b0, cfg.buffer_base} + {1'b0, s2_prod_ff} + {12'd0, s2_xoff_ff};

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         rsp_ff.write_enable  <= s2_we_ff;
         rsp_ff.pixel_address <= s2_we_ff ? addr_sum : 25'd0;
         rsp_ff.write_color   <= s2_color_ff;
         rsp_ff.sprite_done   <= s2_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_skip_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.write_enable) |-> (rsp_data.pixel_address == 25'd0))
      else $error("skipped pixel carries an address");

   a_write_not_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.write_enable) |->
      (rsp_data.write_color != cfg.transparency_key))
      else $error("keyed color written");

endmodule

`default_nettype wire

// ----- design/clipped_color_key_sprite_blit.sv -----
// Color-key sprite blitter with screen clipping, top level.
// Sprite pixels come in on req_*, one word per pixel in raster order;
// the word with first_pixel set latches origin and size and restarts
// the row/column walk.
// Each accepted pixel gives exactly one rsp_* word: write_enable, byte
// address (base + (y*screen_width + x)*pixel_bytes, 0 when skipped), the
// color masked to pixel_bytes, and sprite_done on the last pixel.
// Throughput: one pixel per clock while rsp_ready holds high. Pipeline is
// three registers deep: the scan register, the row-product register, then
// the output register, each result passing through all three in that order.
// Stall: rsp_ready low holds the output register; the stages behind it
// keep filling until full, so req_ready drops only when all three hold.
// Reset (synchronous, active high) empties the pipeline, clears the walk
// state and loads 1024x768, 1 byte/pixel, key 0, base 0.
// Config regs (APB, byte addr 4*i): screen_width, screen_height,
// pixel_bytes, transparency_key, buffer_base. Write only while idle.
// Depends on cksb_pkg, cksb_csr, cksb_scan, cksb_pixel.
`default_nettype none

module clipped_color_key_sprite_blit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // pixel input
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire cksb_pkg::req_type           req_data,
   // write output
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output cksb_pkg::rsp_type                rsp_data,
   // register port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [cksb_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import cksb_pkg::*;

   cfg_type  cfg;
   logic     s1_valid;
   logic     s1_ready;
   walk_type s1_data;

   // register file; presents clamped size, byte count and row stride
   cksb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // walk counters and screen coordinate register
   cksb_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_data   (s1_data)
   );

   // clip, key, row product, then address and output register
   cksb_pixel u_pixel (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .s1_valid  (s1_valid),
      .s1_ready  (s1_ready),
      .s1_data   (s1_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
